// ===== rtl/vwd_pkg.sv =====
// Shared types and constants for the vertex weld/dedup unit.
// No dependencies; imported by vwd_cell and vertex_weld_dedup_unit.
package vwd_pkg;

   localparam int TOL_W      = 31;
   localparam int IN_COORD_W = 32;
   localparam int OUT_IDX_W  = 8;

   typedef struct packed {
      logic active;
      logic found;
   } token_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

// ===== rtl/vwd_cell.sv =====
// One table cell: holds a stored unique vertex and compares it with the
// broadcast query as the search token passes. Depends on vwd_pkg.
module vwd_cell import vwd_pkg::*; #(
   parameter int CW         = 32,
   parameter int IDX_W      = 8,
   parameter int CNT_W      = 9,
   parameter int CELL_INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic        [CNT_W-1:0] count,
   input  logic        [TOL_W-1:0] tolerance,
   input  logic signed [CW-1:0]    query_x,
   input  logic signed [CW-1:0]    query_y,
   input  logic signed [CW-1:0]    query_z,
   input  logic                    wr_en,
   input  logic        [IDX_W-1:0] wr_addr,
   input  token_type               tok_in,
   input  logic        [IDX_W-1:0] idx_in,
   output token_type               tok_out,
   output logic        [IDX_W-1:0] idx_out
);

   localparam int DW    = CW + 1;
   localparam int CMP_W = (DW > TOL_W) ? DW : TOL_W;

   logic signed [CW-1:0] ent_x_ff, ent_y_ff, ent_z_ff;
   token_type            tok_ff, tok_in_d;
   logic     [IDX_W-1:0] idx_ff, idx_in_d;
   logic                 entry_valid, hit;

   function automatic logic close_enough(logic signed [CW-1:0] a,
                                         logic signed [CW-1:0] b,
                                         logic [TOL_W-1:0] tol);
      logic [DW-1:0] diff_ab;
      logic [DW-1:0] diff_ba;
      logic [DW-1:0] mag;
      diff_ab = {a[CW-1], a} - {b[CW-1], b};
      diff_ba = {b[CW-1], b} - {a[CW-1], a};
      mag     = diff_ab[DW-1] ? diff_ba : diff_ab;
      return CMP_W'(mag) <= CMP_W'(tol);
   endfunction

   assign entry_valid = CNT_W'(CELL_INDEX) < count;
   assign hit = entry_valid
                && close_enough(ent_x_ff, query_x, tolerance)
                && close_enough(ent_y_ff, query_y, tolerance)
                && close_enough(ent_z_ff, query_z, tolerance);

   always_comb begin
      tok_in_d.active = tok_in.active;
      tok_in_d.found  = tok_in.found | (tok_in.active & hit);
      idx_in_d        = tok_in.found ? idx_in : IDX_W'(CELL_INDEX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_d;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in_d;
      if (wr_en && (wr_addr == IDX_W'(CELL_INDEX))) begin
         ent_x_ff <= query_x;
         ent_y_ff <= query_y;
         ent_z_ff <= query_z;
      end
   end

   assign tok_out = tok_ff;
   assign idx_out = idx_ff;

endmodule

// ===== rtl/vertex_weld_dedup_unit.sv =====
// Vertex weld/dedup top level: control FSM, query and result registers,
// and the chain of vwd_cell table cells. Depends on vwd_pkg and vwd_cell.
//
//   channel | direction | ports
//   req     | in        | req_valid/req_ready, start_mesh, x/y/z coord
//   rsp     | out       | rsp_valid/rsp_ready, vertex_index, is_new, table_full
//   csr     | in        | csr_wr_en, csr_wr_data (match tolerance)
//
// For each vertex, a req transfer launches the search token, which walks the
// cell chain one cell per cycle; the result is then captured and committed
// to the rsp registers, and the unit returns to idle.
// One vertex is in flight at a time; req_ready is high only while idle.
// A stalled rsp holds the commit in the done state. Reset is synchronous
// and needs no clearing pass; the table is empty once the count is zero.
module vertex_weld_dedup_unit import vwd_pkg::*; #(
   parameter int MAX_UNIQUE  = 256,
   parameter int COORD_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_start_mesh,
   input  logic signed [IN_COORD_W-1:0] req_x_coord,
   input  logic signed [IN_COORD_W-1:0] req_y_coord,
   input  logic signed [IN_COORD_W-1:0] req_z_coord,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic        [OUT_IDX_W-1:0]  rsp_vertex_index,
   output logic                         rsp_is_new,
   output logic                         rsp_table_full,
   input  logic                         csr_wr_en,
   input  logic        [TOL_W-1:0]      csr_wr_data
);

   localparam int CW    = COORD_WIDTH;
   localparam int IDX_W = $clog2(MAX_UNIQUE);
   localparam int CNT_W = $clog2(MAX_UNIQUE + 1);
   localparam int EXT_W = (CNT_W > OUT_IDX_W) ? CNT_W : OUT_IDX_W;

   state_type            state_ff, state_in;
   logic     [TOL_W-1:0] tol_ff;
   logic     [CNT_W-1:0] count_ff, count_in;
   logic signed [CW-1:0] q_x_ff, q_y_ff, q_z_ff;
   logic                 launch_ff;
   logic                 res_found_ff;
   logic     [IDX_W-1:0] res_idx_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                 rsp_new_ff, rsp_new_in;
   logic                 rsp_full_ff, rsp_full_in;

   logic                 req_xfer, commit, table_is_full, wr_en;
   logic     [CNT_W-1:0] sel_idx;
   logic     [EXT_W-1:0] sel_ext;

   token_type            tok_chain [0:MAX_UNIQUE];
   logic     [IDX_W-1:0] idx_chain [0:MAX_UNIQUE];

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_xfer      = req_valid && req_ready;
   assign commit        = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign table_is_full = (count_ff == CNT_W'(MAX_UNIQUE));
   assign wr_en         = commit && !res_found_ff && !table_is_full;

   assign tok_chain[0] = '{active: launch_ff, found: 1'b0};
   assign idx_chain[0] = '0;

   for (genvar i = 0; i < MAX_UNIQUE; i++) begin : g_cell
      vwd_cell #(
         .CW         (CW),
         .IDX_W      (IDX_W),
         .CNT_W      (CNT_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .count     (count_ff),
         .tolerance (tol_ff),
         .query_x   (q_x_ff),
         .query_y   (q_y_ff),
         .query_z   (q_z_ff),
         .wr_en     (wr_en),
         .wr_addr   (count_ff[IDX_W-1:0]),
         .tok_in    (tok_chain[i]),
         .idx_in    (idx_chain[i]),
         .tok_out   (tok_chain[i+1]),
         .idx_out   (idx_chain[i+1])
      );
   end

   always_comb begin
      priority if (res_found_ff) begin
         sel_idx = CNT_W'(res_idx_ff);
      end else if (table_is_full) begin
         sel_idx = CNT_W'(MAX_UNIQUE - 1);
      end else begin
         sel_idx = count_ff;
      end
      sel_ext      = EXT_W'(sel_idx);
      rsp_index_in = (sel_ext > EXT_W'(255)) ? '1 : sel_ext[OUT_IDX_W-1:0];
      rsp_new_in   = !res_found_ff && !table_is_full;
      rsp_full_in  = !res_found_ff && table_is_full;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_RUN;
               if (req_start_mesh) begin
                  count_in = '0;
               end
            end
         end
         ST_RUN: begin
            if (tok_chain[MAX_UNIQUE].active) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tol_ff       <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         launch_ff    <= req_xfer;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         q_x_ff <= CW'(req_x_coord);
         q_y_ff <= CW'(req_y_coord);
         q_z_ff <= CW'(req_z_coord);
      end
      if ((state_ff == ST_RUN) && tok_chain[MAX_UNIQUE].active) begin
         res_found_ff <= tok_chain[MAX_UNIQUE].found;
         res_idx_ff   <= idx_chain[MAX_UNIQUE];
      end
      if (commit) begin
         rsp_index_ff <= rsp_index_in;
         rsp_new_ff   <= rsp_new_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_is_new       = rsp_new_ff;
   assign rsp_table_full   = rsp_full_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_UNIQUE))
      else $error("unique count beyond table size");

   a_launch: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> launch_ff && (state_ff == ST_RUN))
      else $error("search token not launched after transfer");

   a_tail_in_run: assert property (@(posedge clock) disable iff (reset)
      tok_chain[MAX_UNIQUE].active |-> (state_ff == ST_RUN))
      else $error("token left chain outside run state");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + CNT_W'(1)) && rsp_valid && rsp_is_new)
      else $error("append did not advance count");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_new && rsp_table_full))
      else $error("new and full flags both set");
`endif

endmodule
